// ===== rtl/core/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants, codes and types for the Pearson correlation accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 16;

	localparam int CORR_WIDTH   = 16;
	localparam int STATUS_WIDTH = 2;
	localparam int SCOUNT_WIDTH = 16;

	// root search: 16 result bits, target scaled by 2^30
	localparam int ROOT_BITS   = 16;
	localparam int SCALE_SHIFT = 30;

	typedef logic [STATUS_WIDTH-1:0] status_t;
	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_DEGENERATE = 2'd1;
	localparam status_t ST_OVERFLOW   = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_LAUNCH = 7'b0000100,
		S_WAIT   = 7'b0001000,
		S_VCHK   = 7'b0010000,
		S_FIN    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	// which product the shared multiplier is working on
	typedef enum logic [8:0] {
		OP_NXX  = 9'b000000001,
		OP_SXX  = 9'b000000010,
		OP_NYY  = 9'b000000100,
		OP_SYY  = 9'b000001000,
		OP_NXY  = 9'b000010000,
		OP_SXY  = 9'b000100000,
		OP_PROD = 9'b001000000,
		OP_CSQ  = 9'b010000000,
		OP_ROOT = 9'b100000000
	} step_t;

	typedef struct packed {
		logic start;
		logic done;
	} mul_hs_t;

endpackage

`default_nettype wire

// ===== rtl/core/pca_mul.sv =====
// ----------------------------------------------------------------------------
// pca_mul
// Shared shift-add multiplier, one multiplier bit per cycle, modulo 2^W.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_mul #(
	parameter int MUL_W = 160
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [MUL_W-1:0]  a,
	input  wire [MUL_W-1:0]  b,
	output logic             done,
	output logic [MUL_W-1:0] product
);
	import pca_pkg::*;

	logic             busy_q;
	logic [MUL_W-1:0] a_q;
	logic [MUL_W-1:0] b_q;
	logic [MUL_W-1:0] acc_q;

	// finished once no multiplier bits remain
	assign done    = busy_q && (b_q == '0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && !done) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pca_acc.sv =====
// ----------------------------------------------------------------------------
// pca_acc
// Pair count and exact running sums of x, y, xy, x^2 and y^2.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_acc #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 16
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     fire,
	input  wire  [SAMPLE_WIDTH-1:0]                 x,
	input  wire  [SAMPLE_WIDTH-1:0]                 y,
	input  wire                                     clear,
	output logic [COUNT_WIDTH-1:0]                  pair_count,
	output logic                                    overflow_seen,
	output logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0]     sum_x,
	output logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0]     sum_y,
	output logic [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_xy,
	output logic [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_xx,
	output logic [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_yy
);
	import pca_pkg::*;

	localparam int SXW = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int SPW = 2*SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int PW  = 2*SAMPLE_WIDTH;

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   ovf_q;
	logic [SXW-1:0]         sx_q, sy_q;
	logic [SPW-1:0]         sxy_q, sxx_q, syy_q;
	logic [PW-1:0]          pxy, pxx, pyy;
	logic                   take;

	assign pxy  = PW'($signed(x) * $signed(y));
	assign pxx  = PW'($signed(x) * $signed(x));
	assign pyy  = PW'($signed(y) * $signed(y));
	assign take = fire && !ovf_q && !(&count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxy_q   <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
		end else if (clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxy_q   <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
		end else if (take) begin
			count_q <= count_q + 1'b1;
			sx_q    <= sx_q + {{(SXW-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
			sy_q    <= sy_q + {{(SXW-SAMPLE_WIDTH){y[SAMPLE_WIDTH-1]}}, y};
			sxy_q   <= sxy_q + {{(SPW-PW){pxy[PW-1]}}, pxy};
			sxx_q   <= sxx_q + {{(SPW-PW){pxx[PW-1]}}, pxx};
			syy_q   <= syy_q + {{(SPW-PW){pyy[PW-1]}}, pyy};
		end else if (fire && !ovf_q) begin
			// pair arriving at a full count
			ovf_q <= 1'b1;
		end
	end

	assign pair_count    = count_q;
	assign overflow_seen = ovf_q;
	assign sum_x         = sx_q;
	assign sum_y         = sy_q;
	assign sum_xy        = sxy_q;
	assign sum_xx        = sxx_q;
	assign sum_yy        = syy_q;

endmodule

`default_nettype wire

// ===== rtl/core/pca_seq.sv =====
// ----------------------------------------------------------------------------
// pca_seq
// Sequencer: drives the shared multiplier through the variance, covariance
// and square-root search steps and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_seq #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 16,
	parameter int MUL_W        = 160
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_fire,
	input  wire                                     in_last,
	input  wire  [COUNT_WIDTH-1:0]                  pair_count,
	input  wire                                     overflow_seen,
	input  wire  [SAMPLE_WIDTH+COUNT_WIDTH-1:0]     sum_x,
	input  wire  [SAMPLE_WIDTH+COUNT_WIDTH-1:0]     sum_y,
	input  wire  [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_xy,
	input  wire  [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_xx,
	input  wire  [2*SAMPLE_WIDTH+COUNT_WIDTH-1:0]   sum_yy,
	output logic                                    acc_clear,
	output pca_pkg::mul_hs_t                        mul_hs_start,
	input  pca_pkg::mul_hs_t                        mul_hs_done,
	output logic [MUL_W-1:0]                        mul_a,
	output logic [MUL_W-1:0]                        mul_b,
	input  wire  [MUL_W-1:0]                        mul_product,
	output logic                                    in_stall,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output logic [pca_pkg::CORR_WIDTH-1:0]          correlation,
	output logic [pca_pkg::STATUS_WIDTH-1:0]        status,
	output logic [pca_pkg::SCOUNT_WIDTH-1:0]        sample_count
);
	import pca_pkg::*;

	localparam int SXW = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int SPW = 2*SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int RBW = $clog2(ROOT_BITS);
	localparam int TTW = 2*ROOT_BITS;

	state_t                 state_q;
	step_t                  step_q;
	logic [MUL_W-1:0]       tmp_q, vx_q, vy_q;
	logic                   c_neg_q;
	logic [ROOT_BITS-1:0]   m_q;
	logic [RBW-1:0]         bit_q;
	logic [CORR_WIDTH-1:0]  corr_q;
	status_t                status_q;
	logic                   out_valid_q;
	logic [CORR_WIDTH-1:0]  out_corr_q;
	status_t                out_status_q;
	logic [SCOUNT_WIDTH-1:0] out_count_q;

	logic [MUL_W-1:0]       n_ext, sx_ext, sy_ext, sxy_ext, sxx_ext, syy_ext;
	logic [MUL_W-1:0]       diff;
	logic [ROOT_BITS-1:0]   trial;
	logic [TTW-1:0]         trial_sq;
	logic [ROOT_BITS:0]     mag;
	logic [CORR_WIDTH-1:0]  corr_next;
	logic [SCOUNT_WIDTH-1:0] count_out;
	logic                   load_out;

	assign n_ext   = {{(MUL_W-COUNT_WIDTH){1'b0}}, pair_count};
	assign sx_ext  = {{(MUL_W-SXW){sum_x[SXW-1]}}, sum_x};
	assign sy_ext  = {{(MUL_W-SXW){sum_y[SXW-1]}}, sum_y};
	assign sxy_ext = {{(MUL_W-SPW){sum_xy[SPW-1]}}, sum_xy};
	assign sxx_ext = {{(MUL_W-SPW){sum_xx[SPW-1]}}, sum_xx};
	assign syy_ext = {{(MUL_W-SPW){sum_yy[SPW-1]}}, sum_yy};

	assign diff     = tmp_q - mul_product;
	assign trial    = m_q | (ROOT_BITS'(1) << bit_q);
	assign trial_sq = TTW'(trial * trial);

	always_comb begin
		case (step_q)
			OP_NXX:  begin mul_a = n_ext;  mul_b = sxx_ext; end
			OP_SXX:  begin mul_a = sx_ext; mul_b = sx_ext;  end
			OP_NYY:  begin mul_a = n_ext;  mul_b = syy_ext; end
			OP_SYY:  begin mul_a = sy_ext; mul_b = sy_ext;  end
			OP_NXY:  begin mul_a = n_ext;  mul_b = sxy_ext; end
			OP_SXY:  begin mul_a = sx_ext; mul_b = sy_ext;  end
			OP_PROD: begin mul_a = vx_q;   mul_b = vy_q;    end
			OP_CSQ:  begin mul_a = tmp_q;  mul_b = tmp_q;   end
			OP_ROOT: begin mul_a = vx_q;   mul_b = {{(MUL_W-TTW){1'b0}}, trial_sq}; end
			default: begin mul_a = '0;     mul_b = '0;      end
		endcase
	end

	// magnitude clipped to 1.0, then signed Q1.15
	always_comb begin
		mag = (m_q > ROOT_BITS'(32768)) ? (ROOT_BITS+1)'(32768) : {1'b0, m_q};
		if (c_neg_q) begin
			corr_next = CORR_WIDTH'((ROOT_BITS+1)'(65536) - mag);
		end else if (mag > (ROOT_BITS+1)'(32767)) begin
			corr_next = CORR_WIDTH'(32767);
		end else begin
			corr_next = CORR_WIDTH'(mag);
		end
	end

	generate
		if (COUNT_WIDTH >= SCOUNT_WIDTH) begin : g_cnt_trunc
			assign count_out = pair_count[SCOUNT_WIDTH-1:0];
		end else begin : g_cnt_ext
			assign count_out = {{(SCOUNT_WIDTH-COUNT_WIDTH){1'b0}}, pair_count};
		end
	endgenerate

	assign load_out             = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign acc_clear            = load_out;
	assign in_stall             = (state_q != S_IDLE);
	assign mul_hs_start.start   = (state_q == S_LAUNCH);
	assign mul_hs_start.done    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= OP_NXX;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && in_last) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (overflow_seen || pair_count < COUNT_WIDTH'(2)) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= OP_NXX;
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: state_q <= S_WAIT;
				S_WAIT: begin
					if (mul_hs_done.done) begin
						unique case (step_q)
							OP_NXX:  begin step_q <= OP_SXX;  state_q <= S_LAUNCH; end
							OP_SXX:  begin step_q <= OP_NYY;  state_q <= S_LAUNCH; end
							OP_NYY:  begin step_q <= OP_SYY;  state_q <= S_LAUNCH; end
							OP_SYY:  state_q <= S_VCHK;
							OP_NXY:  begin step_q <= OP_SXY;  state_q <= S_LAUNCH; end
							OP_SXY:  begin step_q <= OP_PROD; state_q <= S_LAUNCH; end
							OP_PROD: begin step_q <= OP_CSQ;  state_q <= S_LAUNCH; end
							OP_CSQ:  begin step_q <= OP_ROOT; state_q <= S_LAUNCH; end
							OP_ROOT: state_q <= (bit_q == '0) ? S_FIN : S_LAUNCH;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_VCHK: begin
					if (vx_q == '0 || vy_q == '0) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= OP_NXY;
						state_q <= S_LAUNCH;
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CHECK: begin
				corr_q   <= '0;
				status_q <= overflow_seen ? ST_OVERFLOW :
				            (pair_count < COUNT_WIDTH'(2)) ? ST_DEGENERATE : ST_OK;
			end
			S_VCHK: begin
				if (vx_q == '0 || vy_q == '0) begin
					status_q <= ST_DEGENERATE;
				end
			end
			S_WAIT: begin
				if (mul_hs_done.done) begin
					case (step_q)
						OP_NXX, OP_NYY, OP_NXY: tmp_q <= mul_product;
						OP_SXX:  vx_q <= diff;
						OP_SYY:  vy_q <= diff;
						OP_SXY: begin
							tmp_q   <= diff;
							c_neg_q <= diff[MUL_W-1];
						end
						OP_PROD: vx_q <= mul_product;
						OP_CSQ: begin
							vy_q  <= mul_product << SCALE_SHIFT;
							m_q   <= '0;
							bit_q <= RBW'(ROOT_BITS-1);
						end
						OP_ROOT: begin
							if (mul_product <= vy_q) begin
								m_q <= trial;
							end
							bit_q <= bit_q - 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_FIN: corr_q <= corr_next;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_corr_q   <= corr_q;
			out_status_q <= status_q;
			out_count_q  <= count_out;
		end
	end

	assign out_valid    = out_valid_q;
	assign correlation  = out_corr_q;
	assign status       = out_status_q;
	assign sample_count = out_count_q;

endmodule

`default_nettype wire

// ===== rtl/core/pearson_correlation_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation_accumulator_top
// Streaming Pearson correlation of paired samples, result per data set.
// ----------------------------------------------------------------------------
// Each (x, y) pair is a single transfer: the count and the sums of x, y,
// xy, x^2 and y^2 are registered on it. The pair marked last is summed
// too, then the block holds in_stall high while one shared shift-add
// multiplier (one multiplier bit per cycle, MUL_W = 4*(SAMPLE_WIDTH +
// COUNT_WIDTH) + 32 bits wide) forms the centered variances, covariance,
// their product, the squared covariance and a 16-step square-root search.
// The eight wide products run one after another, then each root step
// runs one product; overflowed or too-short data sets skip them all,
// and a zero variance skips the rest. The result sits in an output
// register; new pairs are taken while it waits. After the result the sums,
// count and overflow flag clear for the next data set.
// ----------------------------------------------------------------------------
`default_nettype none

module pearson_correlation_accumulator_top #(
	parameter int SAMPLE_WIDTH = pca_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = pca_pkg::COUNT_WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [SAMPLE_WIDTH-1:0]            x_sample,
	input  wire  [SAMPLE_WIDTH-1:0]            y_sample,
	input  wire                                last,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [pca_pkg::CORR_WIDTH-1:0]     correlation,
	output logic [pca_pkg::STATUS_WIDTH-1:0]   status,
	output logic [pca_pkg::SCOUNT_WIDTH-1:0]   sample_count
);
	import pca_pkg::*;

	localparam int SXW   = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int SPW   = 2*SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int MUL_W = 4*(SAMPLE_WIDTH + COUNT_WIDTH) + 32;

	logic                   in_fire;
	logic                   acc_clear;
	logic [COUNT_WIDTH-1:0] pair_count;
	logic                   overflow_seen;
	logic [SXW-1:0]         sum_x, sum_y;
	logic [SPW-1:0]         sum_xy, sum_xx, sum_yy;
	mul_hs_t                mul_req, mul_rsp;
	logic [MUL_W-1:0]       mul_a, mul_b, mul_product;

	assign in_fire = in_valid && !in_stall;

	pca_acc #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (in_fire),
		.x             (x_sample),
		.y             (y_sample),
		.clear         (acc_clear),
		.pair_count    (pair_count),
		.overflow_seen (overflow_seen),
		.sum_x         (sum_x),
		.sum_y         (sum_y),
		.sum_xy        (sum_xy),
		.sum_xx        (sum_xx),
		.sum_yy        (sum_yy)
	);

	assign mul_rsp.start = 1'b0;

	pca_mul #(
		.MUL_W (MUL_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_req.start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_rsp.done),
		.product (mul_product)
	);

	pca_seq #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.MUL_W        (MUL_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.in_last       (last),
		.pair_count    (pair_count),
		.overflow_seen (overflow_seen),
		.sum_x         (sum_x),
		.sum_y         (sum_y),
		.sum_xy        (sum_xy),
		.sum_xx        (sum_xx),
		.sum_yy        (sum_yy),
		.acc_clear     (acc_clear),
		.mul_hs_start  (mul_req),
		.mul_hs_done   (mul_rsp),
		.mul_a         (mul_a),
		.mul_b         (mul_b),
		.mul_product   (mul_product),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.correlation   (correlation),
		.status        (status),
		.sample_count  (sample_count)
	);

	// a last pair starts the computation, so the input side closes at once
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> in_stall)
		else $error("input open right after last transfer");

	// degenerate and overflow results carry a zero coefficient
	a_bad_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> correlation == '0)
		else $error("nonzero correlation with bad status");

	// multiplier start never asserted back to back
	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |=> !mul_req.start)
		else $error("back to back multiplier start");

endmodule

`default_nettype wire
